// File: src/sopr_pkg.sv
// Types, constants and the per-pixel color function of the sprite overlay palette remap block
`default_nettype none
package sopr_pkg;

    typedef logic [7:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
    } t_rgba;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned BANK_W      = 24;
    localparam int unsigned NIB_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_HIGH = 1'b1;

    localparam t_chan EGA_HI  = 8'd255;
    localparam t_chan EGA_MID = 8'd170;
    localparam t_chan EGA_LO  = 8'd85;
    localparam t_chan EGA_OFF = 8'd0;

    localparam logic [NIB_W-1:0] IDX_TRANSPARENT = 4'd0;
    localparam logic [NIB_W-1:0] IDX_DARK_GRAY   = 4'd8;

    localparam logic [2:0] NO_REGION = 3'd6;

    // region by index bits 2..0
    localparam logic [2:0] REGION_OF [8] = '{
        NO_REGION, 3'd1, 3'd4, 3'd5, 3'd2, NO_REGION, 3'd3, 3'd0
    };

    function automatic logic [NIB_W-1:0] bank_entry(
        input logic [BANK_W-1:0] bank,
        input logic [2:0]        region
    );
        logic [NIB_W-1:0] ent;
        unique case (region)
            3'd0:    ent = bank[3:0];
            3'd1:    ent = bank[7:4];
            3'd2:    ent = bank[11:8];
            3'd3:    ent = bank[15:12];
            3'd4:    ent = bank[19:16];
            3'd5:    ent = bank[23:20];
            default: ent = '0;
        endcase
        return ent;
    endfunction

    function automatic t_rgba ega_color(input logic [NIB_W-1:0] color);
        t_rgba c;
        c.alpha = EGA_HI;
        case (color)
            4'd0:    begin c.red = EGA_OFF; c.green = EGA_OFF; c.blue = EGA_OFF; end
            4'd1:    begin c.red = EGA_OFF; c.green = EGA_OFF; c.blue = EGA_MID; end
            4'd2:    begin c.red = EGA_OFF; c.green = EGA_MID; c.blue = EGA_OFF; end
            4'd3:    begin c.red = EGA_OFF; c.green = EGA_MID; c.blue = EGA_MID; end
            4'd4:    begin c.red = EGA_MID; c.green = EGA_OFF; c.blue = EGA_OFF; end
            4'd5:    begin c.red = EGA_MID; c.green = EGA_OFF; c.blue = EGA_MID; end
            4'd6:    begin c.red = EGA_MID; c.green = EGA_LO;  c.blue = EGA_OFF; end
            4'd7:    begin c.red = EGA_MID; c.green = EGA_MID; c.blue = EGA_MID; end
            4'd8:    begin c.red = EGA_LO;  c.green = EGA_LO;  c.blue = EGA_LO;  end
            4'd9:    begin c.red = EGA_LO;  c.green = EGA_LO;  c.blue = EGA_HI;  end
            4'd10:   begin c.red = EGA_LO;  c.green = EGA_HI;  c.blue = EGA_LO;  end
            4'd11:   begin c.red = EGA_LO;  c.green = EGA_HI;  c.blue = EGA_HI;  end
            4'd12:   begin c.red = EGA_HI;  c.green = EGA_LO;  c.blue = EGA_LO;  end
            4'd13:   begin c.red = EGA_HI;  c.green = EGA_LO;  c.blue = EGA_HI;  end
            4'd14:   begin c.red = EGA_HI;  c.green = EGA_HI;  c.blue = EGA_LO;  end
            default: begin c.red = EGA_HI;  c.green = EGA_HI;  c.blue = EGA_HI;  end
        endcase
        return c;
    endfunction

    function automatic t_rgba shade_pixel(
        input logic [NIB_W-1:0]  idx,
        input logic [BANK_W-1:0] bank_low,
        input logic [BANK_W-1:0] bank_high
    );
        logic [2:0]       region;
        logic [NIB_W-1:0] color;
        t_rgba            px;
        region = REGION_OF[idx[2:0]];
        // index eight draws black but stays opaque
        color = (idx == IDX_DARK_GRAY) ? IDX_TRANSPARENT : idx;
        if (region != NO_REGION) begin
            color = bank_entry(idx[3] ? bank_high : bank_low, region);
        end
        px = ega_color(color);
        px.alpha = (idx == IDX_TRANSPARENT) ? EGA_OFF : EGA_HI;
        return px;
    endfunction

endpackage
`default_nettype wire

// File: src/sprite_overlay_palette_remap_top.sv
// Sprite overlay palette remap: head over body, region bank remap, EGA palette to RGBA
//
// One request per clock: o_busy never rises, so a request with i_start is taken at every
// edge. Each request carries one packed head byte and one body byte (high nibble is the
// first pixel) and yields one result, which passes the input register and then the result
// register and is shown for exactly one cycle with o_done high; the receiver cannot stall.
// Bank registers are written over the cfg channel, which is always ready, and should only
// change while no request is in flight.
`default_nettype none
module sprite_overlay_palette_remap_top
    import sopr_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    output logic                   o_busy,
    input  wire  [7:0]             i_head_byte,
    input  wire                    i_head_present,
    input  wire  [7:0]             i_body_byte,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [BANK_W-1:0]      i_cfg_data,
    output logic                   o_done,
    output logic [7:0]             o_first_red,
    output logic [7:0]             o_first_green,
    output logic [7:0]             o_first_blue,
    output logic [7:0]             o_first_alpha,
    output logic [7:0]             o_second_red,
    output logic [7:0]             o_second_green,
    output logic [7:0]             o_second_blue,
    output logic [7:0]             o_second_alpha
);

    logic [BANK_W-1:0] r_bank_low;
    logic [BANK_W-1:0] r_bank_high;

    logic              r_in_valid;
    logic [7:0]        r_head;
    logic              r_present;
    logic [7:0]        r_body;

    logic              r_done;
    t_rgba             r_first;
    t_rgba             r_second;

    logic [NIB_W-1:0]  n_idx_first;
    logic [NIB_W-1:0]  n_idx_second;
    t_rgba             n_first;
    t_rgba             n_second;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_low  <= '0;
            r_bank_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BANK_LOW:  r_bank_low  <= i_cfg_data;
                CFG_BANK_HIGH: r_bank_high <= i_cfg_data;
                default:       r_bank_low  <= r_bank_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_head    <= i_head_byte;
            r_present <= i_head_present;
            r_body    <= i_body_byte;
        end
    end

    // nonzero head index wins where the head row is present
    always_comb begin
        n_idx_first  = (r_present && r_head[7:4] != IDX_TRANSPARENT) ? r_head[7:4] : r_body[7:4];
        n_idx_second = (r_present && r_head[3:0] != IDX_TRANSPARENT) ? r_head[3:0] : r_body[3:0];
        n_first      = shade_pixel(n_idx_first, r_bank_low, r_bank_high);
        n_second     = shade_pixel(n_idx_second, r_bank_low, r_bank_high);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_done         = r_done;
    assign o_first_red    = r_first.red;
    assign o_first_green  = r_first.green;
    assign o_first_blue   = r_first.blue;
    assign o_first_alpha  = r_first.alpha;
    assign o_second_red   = r_second.red;
    assign o_second_green = r_second.green;
    assign o_second_blue  = r_second.blue;
    assign o_second_alpha = r_second.alpha;

endmodule
`default_nettype wire

// File: dv/sprite_overlay_palette_remap_checker.sv
// Checker for the sprite overlay palette remap block: predicts each pixel pair and compares
`timescale 1ns / 1ps
module sprite_overlay_palette_remap_checker
    import sopr_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire                    i_busy,
    input  wire  [7:0]             i_head_byte,
    input  wire                    i_head_present,
    input  wire  [7:0]             i_body_byte,
    input  wire                    i_cfg_valid,
    input  wire                    i_cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [BANK_W-1:0]      i_cfg_data,
    input  wire                    i_done,
    input  wire  [7:0]             i_first_red,
    input  wire  [7:0]             i_first_green,
    input  wire  [7:0]             i_first_blue,
    input  wire  [7:0]             i_first_alpha,
    input  wire  [7:0]             i_second_red,
    input  wire  [7:0]             i_second_green,
    input  wire  [7:0]             i_second_blue,
    input  wire  [7:0]             i_second_alpha,
    output int                     o_errors,
    output int                     o_outstanding,
    output int                     o_checked
);

    typedef struct packed {
        t_rgba first;
        t_rgba second;
    } t_pixel_pair;

    // entry 15 first, so entry n sits at bits 24n+23..24n
    localparam logic [16*24-1:0] EGA_PALETTE = {
        {EGA_HI,  EGA_HI,  EGA_HI},  {EGA_HI,  EGA_HI,  EGA_LO},
        {EGA_HI,  EGA_LO,  EGA_HI},  {EGA_HI,  EGA_LO,  EGA_LO},
        {EGA_LO,  EGA_HI,  EGA_HI},  {EGA_LO,  EGA_HI,  EGA_LO},
        {EGA_LO,  EGA_LO,  EGA_HI},  {EGA_LO,  EGA_LO,  EGA_LO},
        {EGA_MID, EGA_MID, EGA_MID}, {EGA_MID, EGA_LO,  EGA_OFF},
        {EGA_MID, EGA_OFF, EGA_MID}, {EGA_MID, EGA_OFF, EGA_OFF},
        {EGA_OFF, EGA_MID, EGA_MID}, {EGA_OFF, EGA_MID, EGA_OFF},
        {EGA_OFF, EGA_OFF, EGA_MID}, {EGA_OFF, EGA_OFF, EGA_OFF}
    };

    // region per index bits 2..0, entry 7 first
    localparam logic [8*3-1:0] REGION_MAP = {
        3'd0, 3'd3, NO_REGION, 3'd2, 3'd5, 3'd4, 3'd1, NO_REGION
    };

    logic [BANK_W-1:0] low_bank      = '0;
    logic [BANK_W-1:0] high_bank     = '0;
    t_pixel_pair       pending_pairs [$];
    int                err_count     = 0;
    int                checked_count = 0;
    int                pending_count = 0;

    assign o_errors      = err_count;
    assign o_checked     = checked_count;
    assign o_outstanding = pending_count;

    function automatic t_rgba shade_index(
        input logic [NIB_W-1:0]  idx,
        input logic [BANK_W-1:0] lo_bank,
        input logic [BANK_W-1:0] hi_bank
    );
        logic [2:0]        region;
        logic [NIB_W-1:0]  pal;
        logic [BANK_W-1:0] bank;
        logic [23:0]       rgb;
        t_rgba             px;
        region = REGION_MAP[3*idx[2:0] +: 3];
        pal    = (idx == IDX_DARK_GRAY) ? IDX_TRANSPARENT : idx;
        if (region != NO_REGION) begin
            bank = idx[3] ? hi_bank : lo_bank;
            pal  = bank[4*region +: 4];
        end
        rgb      = EGA_PALETTE[24*pal +: 24];
        px.red   = rgb[23:16];
        px.green = rgb[15:8];
        px.blue  = rgb[7:0];
        px.alpha = (idx == IDX_TRANSPARENT) ? EGA_OFF : EGA_HI;
        return px;
    endfunction

    function automatic logic [NIB_W-1:0] visible_index(
        input logic [NIB_W-1:0] head,
        input logic [NIB_W-1:0] body,
        input logic             present
    );
        return (present && head != IDX_TRANSPARENT) ? head : body;
    endfunction

    task automatic check_chan(input string name, input t_chan want, input t_chan got);
        if (want !== got) begin
            err_count = err_count + 1;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pixel_pair want;
        t_pixel_pair got;
        if (i_rst_n) begin
            if (i_done) begin
                got.first  = {i_first_red, i_first_green, i_first_blue, i_first_alpha};
                got.second = {i_second_red, i_second_green, i_second_blue, i_second_alpha};
                if (pending_pairs.size() == 0) begin
                    err_count = err_count + 1;
                    $display("%0t ns: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = pending_pairs.pop_front();
                    check_chan("first_red",    want.first.red,    got.first.red);
                    check_chan("first_green",  want.first.green,  got.first.green);
                    check_chan("first_blue",   want.first.blue,   got.first.blue);
                    check_chan("first_alpha",  want.first.alpha,  got.first.alpha);
                    check_chan("second_red",   want.second.red,   got.second.red);
                    check_chan("second_green", want.second.green, got.second.green);
                    check_chan("second_blue",  want.second.blue,  got.second.blue);
                    check_chan("second_alpha", want.second.alpha, got.second.alpha);
                    checked_count = checked_count + 1;
                end
            end
            if (i_start && !i_busy) begin
                want.first = shade_index(
                    visible_index(i_head_byte[7:4], i_body_byte[7:4], i_head_present),
                    low_bank, high_bank);
                want.second = shade_index(
                    visible_index(i_head_byte[3:0], i_body_byte[3:0], i_head_present),
                    low_bank, high_bank);
                pending_pairs.insert(pending_pairs.size(), want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BANK_LOW:  low_bank  = i_cfg_data;
                    CFG_BANK_HIGH: high_bank = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_count <= pending_pairs.size();
    end

endmodule

// File: dv/sprite_overlay_palette_remap_top_test.sv
// Testbench top for the sprite overlay palette remap block: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module sprite_overlay_palette_remap_top_test;
    import sopr_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   start        = 1'b0;
    logic [7:0]             head_byte    = '0;
    logic                   head_present = 1'b0;
    logic [7:0]             body_byte    = '0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_BANK_LOW;
    logic [BANK_W-1:0]      cfg_data     = '0;
    logic                   busy;
    logic                   cfg_ready;
    logic                   done;
    logic [7:0]             first_red, first_green, first_blue, first_alpha;
    logic [7:0]             second_red, second_green, second_blue, second_alpha;

    int errors;
    int outstanding;
    int checked;
    int burst_left   = 0;
    int n_requests   = 0;
    int n_settings   = 0;
    int stall_cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sprite_overlay_palette_remap_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_head_byte    (head_byte),
        .i_head_present (head_present),
        .i_body_byte    (body_byte),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_done         (done),
        .o_first_red    (first_red),
        .o_first_green  (first_green),
        .o_first_blue   (first_blue),
        .o_first_alpha  (first_alpha),
        .o_second_red   (second_red),
        .o_second_green (second_green),
        .o_second_blue  (second_blue),
        .o_second_alpha (second_alpha)
    );

    sprite_overlay_palette_remap_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_head_byte    (head_byte),
        .i_head_present (head_present),
        .i_body_byte    (body_byte),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_done         (done),
        .i_first_red    (first_red),
        .i_first_green  (first_green),
        .i_first_blue   (first_blue),
        .i_first_alpha  (first_alpha),
        .i_second_red   (second_red),
        .i_second_green (second_green),
        .i_second_blue  (second_blue),
        .i_second_alpha (second_alpha),
        .o_errors       (errors),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no activity for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic idle_for(input int unsigned cycles);
        repeat (cycles) begin
            start        <= 1'b0;
            head_byte    <= 8'($urandom);
            head_present <= 1'($urandom);
            body_byte    <= 8'($urandom);
            @(posedge clk);
        end
    endtask

    task automatic send_request(input logic [7:0] head, input logic present,
                                input logic [7:0] body);
        if (burst_left == 0) begin
            idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
        burst_left   = burst_left - 1;
        start        <= 1'b1;
        head_byte    <= head;
        head_present <= present;
        body_byte    <= body;
        do @(posedge clk); while (busy);
        n_requests = n_requests + 1;
    endtask

    // hold off until every result is back, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic load_banks(input logic [BANK_W-1:0] lo, input logic [BANK_W-1:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BANK_LOW;
        cfg_data  <= lo;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_BANK_HIGH;
        cfg_data  <= hi;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings = n_settings + 1;
    endtask

    function automatic logic [3:0] head_nibble();
        return ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom);
    endfunction

    initial begin : stimulus
        logic [BANK_W-1:0] lo;
        logic [BANK_W-1:0] hi;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few requests on reset banks
        send_request(8'h00, 1'b0, 8'h12);
        send_request(8'h9F, 1'b1, 8'h00);
        drain();
        load_banks(24'h654321, 24'hFEDCBA);

        for (int i = 0; i < 8; i++) begin
            send_request(8'hFF, 1'b0, {4'(2*i), 4'(2*i+1)});
            send_request({4'(2*i), 4'(2*i+1)}, 1'b1, 8'h5A);
        end
        send_request(8'h00, 1'b1, 8'hFF);
        send_request(8'h00, 1'b1, 8'h00);
        send_request(8'hF0, 1'b1, 8'h08);
        send_request(8'hFF, 1'b1, 8'h00);
        send_request(8'h00, 1'b0, 8'h00);
        send_request(8'hFF, 1'b0, 8'hFF);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin lo = '1;  hi = '0;  end
                1:       begin lo = '0;  hi = '1;  end
                2:       begin lo = '0;  hi = '0;  end
                default: begin lo = BANK_W'($urandom); hi = BANK_W'($urandom); end
            endcase
            drain();
            load_banks(lo, hi);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request({head_nibble(), head_nibble()},
                             ($urandom_range(0, 3) != 0), 8'($urandom));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Summary: %0d pixel-pair requests across %0d bank settings, %0d results checked",
                 n_requests, n_settings, checked);
        if (errors == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
